// ----- rtl/lfe_pkg.sv -----
// ----------------------------------------------------------------------------
// lfe_pkg
// Shared constants for the light falloff evaluator: register indexes, light
// type codes, reset values and pipeline sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package lfe_pkg;

    localparam int COORD_WIDTH_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_TYPE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POSITION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPOT_DIRECTION = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_RADIUS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_INNER      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_OUTER      = 3'd5;

    localparam logic [1:0] LT_DIRECTIONAL = 2'd0;
    localparam logic [1:0] LT_POINT       = 2'd1;
    localparam logic [1:0] LT_SPOT        = 2'd2;

    localparam logic [1:0]  RST_LIGHT_TYPE     = LT_DIRECTIONAL;
    localparam logic [47:0] RST_LIGHT_POSITION = 48'h0;
    localparam logic [47:0] RST_SPOT_DIRECTION = 48'h0000_C000_0000;
    localparam logic [15:0] RST_LIGHT_RADIUS   = 16'd2560;
    localparam logic [15:0] RST_COS_INNER      = 16'd15652;
    localparam logic [15:0] RST_COS_OUTER      = 16'd11415;

    localparam logic [15:0] ONE_Q15 = 16'h8000;

    // magnitudes are scaled down until they lie below 2^MAG_LIMIT_LOG2
    localparam int MAG_LIMIT_LOG2 = 30;
    // quotient bits of the cosine, attenuation and spot divisions
    localparam int COS_QBITS  = 17;
    localparam int ATT_QBITS  = 15;
    localparam int SPOT_QBITS = 16;

endpackage

`default_nettype wire

// ----- rtl/light_falloff_evaluator_top.sv -----
// ----------------------------------------------------------------------------
// light_falloff_evaluator_top
// Point/spot light attenuation (a directional light gives full values): range
// test, distance falloff and cone falloff of one configured light for a stream of points.
// ----------------------------------------------------------------------------
// Fully pipelined: one point may be started in every cycle and busy stays low.
// Each result appears once, with o_valid high for one cycle. The pipeline
// runs through the input stages A1 to A3, the bit-per-stage square root (NQ
// stages, where NQ = min(COORD_WIDTH + 1, 30) + 1), the 17-stage cosine and
// attenuation divider, stage D0, the 16-stage spot divider and the outputs.
// Registers may be written only when no point is in flight.
`default_nettype none

module light_falloff_evaluator_top #(
    parameter int COORD_WIDTH = lfe_pkg::COORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_WIDTH-1:0]       i_point_x,
    input  logic signed [COORD_WIDTH-1:0]       i_point_y,
    input  logic signed [COORD_WIDTH-1:0]       i_point_z,
    input  logic                                i_cfg_we,
    input  logic [lfe_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfe_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                o_valid,
    output logic                                o_in_range,
    output logic [15:0]                         o_attenuation,
    output logic [15:0]                         o_spot_factor
);

    localparam int CW     = COORD_WIDTH;
    localparam int DW     = CW + 1;
    localparam int LIM    = lfe_pkg::MAG_LIMIT_LOG2;
    localparam int MAG_W  = (DW > LIM) ? LIM : DW;
    localparam int NQ     = MAG_W + 1;
    localparam int RW     = NQ + 2;
    localparam int SQ_W   = 2 * NQ;
    localparam int PR_W   = MAG_W + 17;
    localparam int DOT_W  = PR_W + 2;
    localparam int CMP_W  = (SQ_W > 32) ? SQ_W : 32;
    localparam int AW     = (NQ > 16) ? NQ : 16;
    localparam int CQ     = lfe_pkg::COS_QBITS;
    localparam int AQ     = lfe_pkg::ATT_QBITS;
    localparam int SQB    = lfe_pkg::SPOT_QBITS;
    localparam int COS_W  = CQ + 1;
    localparam int POS_W  = 3 * CW + lfe_pkg::CFG_DATA_W;

    // ---------------- configuration ----------------
    logic [1:0]  r_light_type;
    logic [47:0] r_light_position;
    logic [47:0] r_spot_direction;
    logic [15:0] r_light_radius;
    logic [15:0] r_cos_inner;
    logic [15:0] r_cos_outer;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_type     <= lfe_pkg::RST_LIGHT_TYPE;
            r_light_position <= lfe_pkg::RST_LIGHT_POSITION;
            r_spot_direction <= lfe_pkg::RST_SPOT_DIRECTION;
            r_light_radius   <= lfe_pkg::RST_LIGHT_RADIUS;
            r_cos_inner      <= lfe_pkg::RST_COS_INNER;
            r_cos_outer      <= lfe_pkg::RST_COS_OUTER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lfe_pkg::CFG_LIGHT_TYPE:     r_light_type     <= i_cfg_data[1:0];
                lfe_pkg::CFG_LIGHT_POSITION: r_light_position <= i_cfg_data[47:0];
                lfe_pkg::CFG_SPOT_DIRECTION: r_spot_direction <= i_cfg_data[47:0];
                lfe_pkg::CFG_LIGHT_RADIUS:   r_light_radius   <= i_cfg_data[15:0];
                lfe_pkg::CFG_COS_INNER:      r_cos_inner      <= i_cfg_data[15:0];
                lfe_pkg::CFG_COS_OUTER:      r_cos_outer      <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------- stage A1: difference, magnitude, range scaling ----------------
    logic                    r_a1_vld;
    logic [MAG_W-1:0]        r_a1_mag [3];
    logic [2:0]              r_a1_neg;
    logic                    r_a1_far;

    logic signed [CW-1:0]    a1_pt  [3];
    logic signed [DW-1:0]    a1_d   [3];
    logic [DW-1:0]           a1_m   [3];
    logic [DW-1:0]           a1_or;
    logic [1:0]              a1_sh;
    logic                    a1_found;
    logic [POS_W-1:0]        a1_pos;
    logic [MAG_W-1:0]        n_a1_mag [3];
    logic [2:0]              n_a1_neg;

    always_comb begin
        a1_pt[0] = i_point_x;
        a1_pt[1] = i_point_y;
        a1_pt[2] = i_point_z;
        a1_pos   = POS_W'(r_light_position);
        a1_or    = '0;
        for (int i = 0; i < 3; i++) begin
            a1_d[i] = DW'(a1_pt[i]) - DW'($signed(a1_pos[i*CW +: CW]));
            a1_m[i] = a1_d[i][DW-1] ? DW'(-a1_d[i]) : DW'(a1_d[i]);
            a1_or   = a1_or | a1_m[i];
        end
        a1_sh    = 2'd0;
        a1_found = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (!a1_found && ((64'(a1_or) >> k) < (64'd1 << LIM))) begin
                a1_sh    = 2'(k);
                a1_found = 1'b1;
            end
        end
        for (int i = 0; i < 3; i++) begin
            n_a1_mag[i] = MAG_W'(a1_m[i] >> a1_sh);
            n_a1_neg[i] = a1_d[i][DW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_vld <= 1'b0;
        end else begin
            r_a1_vld <= start;
        end
        r_a1_mag <= n_a1_mag;
        r_a1_neg <= n_a1_neg;
        r_a1_far <= (a1_sh != 2'd0);
    end

    // ---------------- stage A2: squares and direction products ----------------
    logic                    r_a2_vld;
    logic [2*MAG_W-1:0]      r_a2_sq [3];
    logic signed [PR_W-1:0]  r_a2_pr [3];
    logic                    r_a2_far;

    logic signed [MAG_W:0]   a2_sv [3];
    logic signed [15:0]      a2_dl [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a2_sv[i] = r_a1_neg[i] ? -$signed({1'b0, r_a1_mag[i]})
                                   : $signed({1'b0, r_a1_mag[i]});
            a2_dl[i] = $signed(r_spot_direction[16*i +: 16]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a2_vld <= 1'b0;
        end else begin
            r_a2_vld <= r_a1_vld;
        end
        for (int i = 0; i < 3; i++) begin
            r_a2_sq[i] <= (2*MAG_W)'(r_a1_mag[i]) * (2*MAG_W)'(r_a1_mag[i]);
            r_a2_pr[i] <= PR_W'(a2_sv[i]) * PR_W'(a2_dl[i]);
        end
        r_a2_far <= r_a1_far;
    end

    // ---------------- stage A3: sums ----------------
    logic                    r_a3_vld;
    logic [SQ_W-1:0]         r_a3_distsq;
    logic signed [DOT_W-1:0] r_a3_dot;
    logic                    r_a3_far;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a3_vld <= 1'b0;
        end else begin
            r_a3_vld <= r_a2_vld;
        end
        r_a3_distsq <= SQ_W'(r_a2_sq[0]) + SQ_W'(r_a2_sq[1]) + SQ_W'(r_a2_sq[2]);
        r_a3_dot    <= -(DOT_W'(r_a2_pr[0]) + DOT_W'(r_a2_pr[1]) + DOT_W'(r_a2_pr[2]));
        r_a3_far    <= r_a2_far;
    end

    // ---------------- B: square root, one root bit per stage ----------------
    logic [NQ-1:0]    r_b_vld, n_b_vld;
    logic [NQ-1:0]    r_b_far, n_b_far;
    logic [NQ-1:0]    r_b_inr, n_b_inr;
    logic [NQ-1:0]    r_b_dneg, n_b_dneg;
    logic [DOT_W-1:0] r_b_dmag [NQ];
    logic [DOT_W-1:0] n_b_dmag [NQ];
    logic [RW-1:0]    r_b_rem  [NQ];
    logic [RW-1:0]    n_b_rem  [NQ];
    logic [NQ-1:0]    r_b_root [NQ];
    logic [NQ-1:0]    n_b_root [NQ];
    logic [SQ_W-1:0]  r_b_x    [NQ];
    logic [SQ_W-1:0]  n_b_x    [NQ];

    logic [RW-1:0]    b_rem_in  [NQ];
    logic [NQ-1:0]    b_root_in [NQ];
    logic [SQ_W-1:0]  b_x_in    [NQ];
    logic [RW-1:0]    b_tr;
    logic [RW-1:0]    b_tt;

    always_comb begin
        n_b_vld[0]  = r_a3_vld;
        n_b_far[0]  = r_a3_far;
        n_b_inr[0]  = !r_a3_far && (CMP_W'(r_a3_distsq) <=
                      CMP_W'(32'(r_light_radius) * 32'(r_light_radius)));
        n_b_dneg[0] = r_a3_dot[DOT_W-1];
        n_b_dmag[0] = r_a3_dot[DOT_W-1] ? DOT_W'(-r_a3_dot) : DOT_W'(r_a3_dot);
        b_rem_in[0]  = '0;
        b_root_in[0] = '0;
        b_x_in[0]    = r_a3_distsq;
        for (int k = 1; k < NQ; k++) begin
            n_b_vld[k]   = r_b_vld[k-1];
            n_b_far[k]   = r_b_far[k-1];
            n_b_inr[k]   = r_b_inr[k-1];
            n_b_dneg[k]  = r_b_dneg[k-1];
            n_b_dmag[k]  = r_b_dmag[k-1];
            b_rem_in[k]  = r_b_rem[k-1];
            b_root_in[k] = r_b_root[k-1];
            b_x_in[k]    = r_b_x[k-1];
        end
        for (int k = 0; k < NQ; k++) begin
            b_tr = {b_rem_in[k][RW-3:0], b_x_in[k][SQ_W-1 -: 2]};
            b_tt = {b_root_in[k], 2'b01};
            if (b_tr >= b_tt) begin
                n_b_rem[k]  = b_tr - b_tt;
                n_b_root[k] = {b_root_in[k][NQ-2:0], 1'b1};
            end else begin
                n_b_rem[k]  = b_tr;
                n_b_root[k] = {b_root_in[k][NQ-2:0], 1'b0};
            end
            n_b_x[k] = {b_x_in[k][SQ_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= '0;
        end else begin
            r_b_vld <= n_b_vld;
        end
        r_b_far  <= n_b_far;
        r_b_inr  <= n_b_inr;
        r_b_dneg <= n_b_dneg;
        r_b_dmag <= n_b_dmag;
        r_b_rem  <= n_b_rem;
        r_b_root <= n_b_root;
        r_b_x    <= n_b_x;
    end

    // ---------------- C: cosine and attenuation dividers ----------------
    logic [CQ-1:0]    r_c_vld, n_c_vld;
    logic [CQ-1:0]    r_c_inr, n_c_inr;
    logic [CQ-1:0]    r_c_dneg, n_c_dneg;
    logic [CQ-1:0]    r_c_az, n_c_az;
    logic [NQ-1:0]    r_c_dist [CQ];
    logic [NQ-1:0]    n_c_dist [CQ];
    logic [DOT_W-1:0] r_c_crem [CQ];
    logic [DOT_W-1:0] n_c_crem [CQ];
    logic [CQ-1:0]    r_c_cq   [CQ];
    logic [CQ-1:0]    n_c_cq   [CQ];
    logic [15:0]      r_c_arem [CQ];
    logic [15:0]      n_c_arem [CQ];
    logic [AQ-1:0]    r_c_aq   [CQ];
    logic [AQ-1:0]    n_c_aq   [CQ];

    logic [DOT_W-1:0] c_crem_in [CQ];
    logic [CQ-1:0]    c_cq_in   [CQ];
    logic [15:0]      c_arem_in [CQ];
    logic [AQ-1:0]    c_aq_in   [CQ];
    logic [NQ-1:0]    c_dist0;
    logic [DOT_W:0]   c_div;
    logic [16:0]      c_r2;

    always_comb begin
        c_dist0      = r_b_root[NQ-1];
        n_c_vld[0]   = r_b_vld[NQ-1];
        n_c_inr[0]   = r_b_inr[NQ-1];
        n_c_dneg[0]  = r_b_dneg[NQ-1];
        n_c_az[0]    = r_b_far[NQ-1] || (r_light_radius == 16'd0) ||
                       (AW'(c_dist0) >= AW'(r_light_radius));
        n_c_dist[0]  = c_dist0;
        c_crem_in[0] = r_b_dmag[NQ-1];
        c_cq_in[0]   = '0;
        c_arem_in[0] = 16'(c_dist0);
        c_aq_in[0]   = '0;
        for (int k = 1; k < CQ; k++) begin
            n_c_vld[k]   = r_c_vld[k-1];
            n_c_inr[k]   = r_c_inr[k-1];
            n_c_dneg[k]  = r_c_dneg[k-1];
            n_c_az[k]    = r_c_az[k-1];
            n_c_dist[k]  = r_c_dist[k-1];
            c_crem_in[k] = r_c_crem[k-1];
            c_cq_in[k]   = r_c_cq[k-1];
            c_arem_in[k] = r_c_arem[k-1];
            c_aq_in[k]   = r_c_aq[k-1];
        end
        for (int k = 0; k < CQ; k++) begin
            c_div = (DOT_W+1)'(n_c_dist[k]) << (CQ - 1 - k);
            if ({1'b0, c_crem_in[k]} >= c_div) begin
                n_c_crem[k] = DOT_W'({1'b0, c_crem_in[k]} - c_div);
                n_c_cq[k]   = {c_cq_in[k][CQ-2:0], 1'b1};
            end else begin
                n_c_crem[k] = c_crem_in[k];
                n_c_cq[k]   = {c_cq_in[k][CQ-2:0], 1'b0};
            end
            c_r2 = {c_arem_in[k], 1'b0};
            if (k >= AQ) begin
                n_c_arem[k] = c_arem_in[k];
                n_c_aq[k]   = c_aq_in[k];
            end else if (c_r2 >= {1'b0, r_light_radius}) begin
                n_c_arem[k] = 16'(c_r2 - {1'b0, r_light_radius});
                n_c_aq[k]   = {c_aq_in[k][AQ-2:0], 1'b1};
            end else begin
                n_c_arem[k] = c_r2[15:0];
                n_c_aq[k]   = {c_aq_in[k][AQ-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= '0;
        end else begin
            r_c_vld <= n_c_vld;
        end
        r_c_inr  <= n_c_inr;
        r_c_dneg <= n_c_dneg;
        r_c_az   <= n_c_az;
        r_c_dist <= n_c_dist;
        r_c_crem <= n_c_crem;
        r_c_cq   <= n_c_cq;
        r_c_arem <= n_c_arem;
        r_c_aq   <= n_c_aq;
    end

    // ---------------- D0: cosine sign, cone classification ----------------
    logic              r_d0_vld;
    logic              r_d0_inr;
    logic [15:0]       r_d0_a;
    logic              r_d0_lo;
    logic              r_d0_hi;
    logic [16:0]       r_d0_num;
    logic [16:0]       r_d0_den;

    logic signed [COS_W-1:0] d0_cos;
    logic signed [COS_W-1:0] d0_ci;
    logic signed [COS_W-1:0] d0_co;
    logic                    d0_lo;
    logic [CQ-1:0]           d0_q;

    always_comb begin
        d0_q  = r_c_cq[CQ-1];
        d0_ci = COS_W'($signed(r_cos_inner));
        d0_co = COS_W'($signed(r_cos_outer));
        if (r_c_dist[CQ-1] == '0) begin
            d0_cos = '0;
        end else if (r_c_dneg[CQ-1]) begin
            d0_cos = -$signed({1'b0, d0_q});
        end else begin
            d0_cos = $signed({1'b0, d0_q});
        end
        d0_lo = (d0_cos < d0_co);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d0_vld <= 1'b0;
        end else begin
            r_d0_vld <= r_c_vld[CQ-1];
        end
        r_d0_inr <= r_c_inr[CQ-1];
        r_d0_a   <= r_c_az[CQ-1] ? 16'd0 : 16'(17'h08000 - 17'(r_c_aq[CQ-1]));
        r_d0_lo  <= d0_lo;
        r_d0_hi  <= !d0_lo && ((d0_cos > d0_ci) || (d0_ci == d0_co));
        r_d0_num <= 17'(d0_cos - d0_co);
        r_d0_den <= 17'(d0_ci - d0_co);
    end

    // ---------------- D: spot divider ----------------
    logic [SQB-1:0] r_d_vld, n_d_vld;
    logic [SQB-1:0] r_d_inr, n_d_inr;
    logic [SQB-1:0] r_d_lo, n_d_lo;
    logic [SQB-1:0] r_d_hi, n_d_hi;
    logic [15:0]    r_d_a   [SQB];
    logic [15:0]    n_d_a   [SQB];
    logic [16:0]    r_d_den [SQB];
    logic [16:0]    n_d_den [SQB];
    logic [16:0]    r_d_rem [SQB];
    logic [16:0]    n_d_rem [SQB];
    logic [SQB-1:0] r_d_t   [SQB];
    logic [SQB-1:0] n_d_t   [SQB];

    logic [16:0]    d_rem_in [SQB];
    logic [SQB-1:0] d_t_in   [SQB];
    logic [17:0]    d_r2;

    always_comb begin
        n_d_vld[0]  = r_d0_vld;
        n_d_inr[0]  = r_d0_inr;
        n_d_lo[0]   = r_d0_lo;
        n_d_hi[0]   = r_d0_hi;
        n_d_a[0]    = r_d0_a;
        n_d_den[0]  = r_d0_den;
        d_rem_in[0] = r_d0_num;
        d_t_in[0]   = '0;
        for (int k = 1; k < SQB; k++) begin
            n_d_vld[k]  = r_d_vld[k-1];
            n_d_inr[k]  = r_d_inr[k-1];
            n_d_lo[k]   = r_d_lo[k-1];
            n_d_hi[k]   = r_d_hi[k-1];
            n_d_a[k]    = r_d_a[k-1];
            n_d_den[k]  = r_d_den[k-1];
            d_rem_in[k] = r_d_rem[k-1];
            d_t_in[k]   = r_d_t[k-1];
        end
        for (int k = 0; k < SQB; k++) begin
            d_r2 = (k == 0) ? {1'b0, d_rem_in[k]} : {d_rem_in[k], 1'b0};
            if (d_r2 >= {1'b0, n_d_den[k]}) begin
                n_d_rem[k] = 17'(d_r2 - {1'b0, n_d_den[k]});
                n_d_t[k]   = {d_t_in[k][SQB-2:0], 1'b1};
            end else begin
                n_d_rem[k] = d_r2[16:0];
                n_d_t[k]   = {d_t_in[k][SQB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= '0;
        end else begin
            r_d_vld <= n_d_vld;
        end
        r_d_inr <= n_d_inr;
        r_d_lo  <= n_d_lo;
        r_d_hi  <= n_d_hi;
        r_d_a   <= n_d_a;
        r_d_den <= n_d_den;
        r_d_rem <= n_d_rem;
        r_d_t   <= n_d_t;
    end

    // ---------------- output: squares and light type selection ----------------
    logic [31:0] f_asq;
    logic [31:0] f_tsq;
    logic [15:0] f_spot;

    always_comb begin
        f_asq = 32'(r_d_a[SQB-1]) * 32'(r_d_a[SQB-1]);
        f_tsq = 32'(r_d_t[SQB-1]) * 32'(r_d_t[SQB-1]);
        priority if (r_d_lo[SQB-1]) begin
            f_spot = 16'd0;
        end else if (r_d_hi[SQB-1]) begin
            f_spot = lfe_pkg::ONE_Q15;
        end else begin
            f_spot = f_tsq[30:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_d_vld[SQB-1];
        end
        if (r_light_type == lfe_pkg::LT_DIRECTIONAL) begin
            o_in_range    <= 1'b1;
            o_attenuation <= lfe_pkg::ONE_Q15;
            o_spot_factor <= lfe_pkg::ONE_Q15;
        end else begin
            o_in_range    <= r_d_inr[SQB-1];
            o_attenuation <= f_asq[30:15];
            o_spot_factor <= (r_light_type == lfe_pkg::LT_SPOT) ? f_spot
                                                               : lfe_pkg::ONE_Q15;
        end
    end

endmodule

`default_nettype wire
